// File: rtl/bdhe_pkg.sv
// shared types, constants and helpers for the button debouncer
package bdhe_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int AGE_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [AGE_W-1:0] AGE_MAX           = {AGE_W{1'b1}};
  localparam logic [AGE_W-1:0] DEBOUNCE_TIME_RST = 16'd50;
  localparam logic [AGE_W-1:0] HOLD_TIME_RST     = 16'd1000;
  localparam logic [AGE_W-1:0] EDGE_WINDOW_RST   = 16'd40;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_RISE = 2'd1,
    CMD_FALL = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TIME = 2'd0,
    REG_HOLD_TIME     = 2'd1,
    REG_EDGE_WINDOW   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_RELEASED = 3'b001,
    MODE_PRESSED  = 3'b010,
    MODE_HELD     = 3'b100
  } mode_t;

  typedef struct packed {
    logic [AGE_W-1:0] debounce_time;
    logic [AGE_W-1:0] hold_time;
    logic [AGE_W-1:0] edge_window;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic query_rise;
    logic query_fall;
    logic pin_high;
  } lane_ctrl_t;

  typedef struct packed {
    logic pressed;
    logic held;
    logic seen;
  } lane_status_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
  endfunction

endpackage

// File: rtl/bdhe_lane.sv
// one button lane: debounce state machine, age counters and edge flags
module bdhe_lane
  import bdhe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lane_ctrl_t   ctrl,
  input  cfg_t         cfg,
  input  logic         uptime_ok,
  output lane_status_t status
);

  mode_t            mode_r, mode_nxt;
  logic [AGE_W-1:0] debounce_age_r, debounce_age_nxt;
  logic [AGE_W-1:0] hold_age_r, hold_age_nxt;
  logic [AGE_W-1:0] rise_age_r, rise_age_nxt;
  logic [AGE_W-1:0] fall_age_r, fall_age_nxt;
  logic             seen;

  always_comb begin
    mode_nxt         = mode_r;
    debounce_age_nxt = debounce_age_r;
    hold_age_nxt     = hold_age_r;
    rise_age_nxt     = rise_age_r;
    fall_age_nxt     = fall_age_r;
    seen             = 1'b0;
    if (ctrl.tick) begin
      debounce_age_nxt = age_inc(debounce_age_r);
      hold_age_nxt     = age_inc(hold_age_r);
      rise_age_nxt     = age_inc(rise_age_r);
      fall_age_nxt     = age_inc(fall_age_r);
      case (mode_r)
        MODE_RELEASED: begin
          if (ctrl.pin_high) begin
            debounce_age_nxt = '0;
          end
          if (debounce_age_nxt >= cfg.debounce_time) begin
            rise_age_nxt     = '0;
            hold_age_nxt     = '0;
            debounce_age_nxt = '0;
            mode_nxt         = MODE_PRESSED;
          end
        end
        MODE_PRESSED, MODE_HELD: begin
          if (!ctrl.pin_high) begin
            debounce_age_nxt = '0;
            if (hold_age_nxt >= cfg.hold_time) begin
              mode_nxt = MODE_HELD;
            end
          end
          if (debounce_age_nxt >= cfg.debounce_time) begin
            fall_age_nxt     = '0;
            debounce_age_nxt = '0;
            mode_nxt         = MODE_RELEASED;
          end
        end
        default: mode_nxt = MODE_RELEASED;
      endcase
    end else if (ctrl.query_rise) begin
      seen         = (rise_age_r < cfg.edge_window) && uptime_ok;
      rise_age_nxt = AGE_MAX;
    end else if (ctrl.query_fall) begin
      seen         = (fall_age_r < cfg.edge_window) && uptime_ok;
      fall_age_nxt = AGE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_RELEASED;
      debounce_age_r <= '0;
      hold_age_r     <= '0;
      rise_age_r     <= AGE_MAX;
      fall_age_r     <= AGE_MAX;
    end else begin
      mode_r         <= mode_nxt;
      debounce_age_r <= debounce_age_nxt;
      hold_age_r     <= hold_age_nxt;
      rise_age_r     <= rise_age_nxt;
      fall_age_r     <= fall_age_nxt;
    end
  end

  assign status.pressed = (mode_nxt != MODE_RELEASED);
  assign status.held    = (mode_nxt == MODE_HELD);
  assign status.seen    = seen;

  // a fresh press leaves the button pressed, not yet held
  a_rise_zero_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (rise_age_r == '0) |-> (mode_r == MODE_PRESSED))
    else $error("rise age zero outside pressed mode");

  a_hold_zero_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_age_r == '0) |-> (mode_r != MODE_HELD))
    else $error("hold age zero in held mode");

  a_fall_zero_released: assert property (@(posedge clk) disable iff (!rst_n)
    (fall_age_r == '0) |-> (mode_r == MODE_RELEASED))
    else $error("fall age zero outside released mode");

endmodule

// File: rtl/bdhe_merge.sv
// merge stage: builds masks from the lanes and holds the result word
module bdhe_merge
  import bdhe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  lane_status_t           lanes [NUM_BUTTONS],
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [NUM_BUTTONS-1:0] out_pressed_mask,
  output logic [NUM_BUTTONS-1:0] out_held_mask,
  output logic                   out_edge_seen
);

  logic                   out_valid_r, out_valid_nxt;
  logic [NUM_BUTTONS-1:0] pressed_r, pressed_nxt;
  logic [NUM_BUTTONS-1:0] held_r, held_nxt;
  logic                   seen_r, seen_nxt;

  always_comb begin
    seen_nxt = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      pressed_nxt[i] = lanes[i].pressed;
      held_nxt[i]    = lanes[i].held;
      seen_nxt       = seen_nxt | lanes[i].seen;
    end
  end

  assign out_valid_nxt = load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pressed_r <= pressed_nxt;
      held_r    <= held_nxt;
      seen_r    <= seen_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pressed_mask = pressed_r;
  assign out_held_mask    = held_r;
  assign out_edge_seen    = seen_r;

endmodule

// File: rtl/button_debounce_hold_edge.sv
// top level of the debouncer with long-press and edge query
// Debounces NUM_BUTTONS active-low buttons. Each input word is a
// millisecond tick carrying all pin levels, a rising/falling edge query
// that reads and clears one button's edge flag, or the spare code, which
// changes no state. Every accepted word gives exactly one result word with
// the pressed and held masks and the query answer. One word is accepted
// per cycle while no result is held or out_ready is high: all button lanes
// update in the accept cycle and the merge stage registers the result, and
// a new word is taken in the same cycle the previous result leaves the
// output register. Configuration writes take effect on the next cycle.
module button_debounce_hold_edge
  import bdhe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  logic [NUM_BUTTONS-1:0] in_pin_levels,
  input  logic                   in_button_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [NUM_BUTTONS-1:0] out_pressed_mask,
  output logic [NUM_BUTTONS-1:0] out_held_mask,
  output logic                   out_edge_seen,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [AGE_W-1:0]       cfg_wdata
);

  cfg_t             cfg_r, cfg_nxt;
  logic [AGE_W-1:0] uptime_r, uptime_nxt;
  logic             accept;
  logic             is_tick, is_rise, is_fall;
  logic             uptime_ok;
  lane_ctrl_t       lane_ctrl [NUM_BUTTONS];
  lane_status_t     lane_stat [NUM_BUTTONS];

  assign accept = in_valid & in_ready;

  always_comb begin
    is_tick = 1'b0;
    is_rise = 1'b0;
    is_fall = 1'b0;
    case (in_cmd)
      CMD_TICK: is_tick = 1'b1;
      CMD_RISE: is_rise = 1'b1;
      CMD_FALL: is_fall = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME: cfg_nxt.debounce_time = cfg_wdata;
        REG_HOLD_TIME:     cfg_nxt.hold_time     = cfg_wdata;
        REG_EDGE_WINDOW:   cfg_nxt.edge_window   = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign uptime_nxt = (accept && is_tick) ? age_inc(uptime_r) : uptime_r;
  assign uptime_ok  = (uptime_r >= cfg_r.edge_window);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time <= DEBOUNCE_TIME_RST;
      cfg_r.hold_time     <= HOLD_TIME_RST;
      cfg_r.edge_window   <= EDGE_WINDOW_RST;
      uptime_r            <= '0;
    end else begin
      cfg_r    <= cfg_nxt;
      uptime_r <= uptime_nxt;
    end
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic sel;
    assign sel = (32'(in_button_index) == g);
    assign lane_ctrl[g].tick       = accept & is_tick;
    assign lane_ctrl[g].query_rise = accept & is_rise & sel;
    assign lane_ctrl[g].query_fall = accept & is_fall & sel;
    assign lane_ctrl[g].pin_high   = in_pin_levels[g];

    bdhe_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (lane_ctrl[g]),
      .cfg       (cfg_r),
      .uptime_ok (uptime_ok),
      .status    (lane_stat[g])
    );
  end

  bdhe_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (accept),
    .lanes            (lane_stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_pressed_mask (out_pressed_mask),
    .out_held_mask    (out_held_mask),
    .out_edge_seen    (out_edge_seen)
  );

  assign in_ready = ~out_valid | out_ready;

endmodule

// File: tb/button_debounce_hold_edge_test.sv
// self-checking testbench for the button debouncer with hold detection and edge queries
module button_debounce_hold_edge_test;
  import bdhe_pkg::*;

  localparam int CYCLE_LIMIT = 60000;
  localparam int RX_PAUSE_CYCLES = 300;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [NUM_BUTTONS-1:0] pins;
    logic                   idx;
  } button_word_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] held;
    logic                   seen;
  } button_status_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_cmd = CMD_TICK;
  logic [NUM_BUTTONS-1:0] in_pin_levels = '1;
  logic                   in_button_index = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [NUM_BUTTONS-1:0] out_pressed_mask;
  logic [NUM_BUTTONS-1:0] out_held_mask;
  logic                   out_edge_seen;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_DEBOUNCE_TIME;
  logic [AGE_W-1:0]       cfg_wdata = '0;

  button_word_t   pending_words[$];
  button_status_t expected_status[$];

  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int rx_pause_req = 0;
  int rx_pause_seen = 0;
  int rx_pause_left = 0;
  logic [NUM_BUTTONS-1:0] pin_rest = '1;

  // debouncer state as predicted
  logic [AGE_W-1:0] debounce_ms;
  logic [AGE_W-1:0] hold_ms;
  logic [AGE_W-1:0] window_ms;
  mode_t            lane_mode     [NUM_BUTTONS];
  logic [AGE_W-1:0] stable_ms     [NUM_BUTTONS];
  logic [AGE_W-1:0] down_ms       [NUM_BUTTONS];
  logic [AGE_W-1:0] since_press   [NUM_BUTTONS];
  logic [AGE_W-1:0] since_release [NUM_BUTTONS];
  logic [AGE_W-1:0] uptime;

  button_debounce_hold_edge dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_pin_levels    (in_pin_levels),
    .in_button_index  (in_button_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pressed_mask (out_pressed_mask),
    .out_held_mask    (out_held_mask),
    .out_edge_seen    (out_edge_seen),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] a);
    return (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
  endfunction

  function automatic void clear_debouncer();
    debounce_ms = DEBOUNCE_TIME_RST;
    hold_ms = HOLD_TIME_RST;
    window_ms = EDGE_WINDOW_RST;
    uptime = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      lane_mode[b] = MODE_RELEASED;
      stable_ms[b] = '0;
      down_ms[b] = '0;
      since_press[b] = AGE_MAX;
      since_release[b] = AGE_MAX;
    end
  endfunction

  function automatic button_status_t apply_word(input button_word_t w);
    button_status_t s;
    logic high;
    s = '0;
    case (w.cmd)
      CMD_TICK: begin
        uptime = sat_inc(uptime);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          high = w.pins[b];
          stable_ms[b] = sat_inc(stable_ms[b]);
          down_ms[b] = sat_inc(down_ms[b]);
          since_press[b] = sat_inc(since_press[b]);
          since_release[b] = sat_inc(since_release[b]);
          if (lane_mode[b] == MODE_RELEASED) begin
            if (high) stable_ms[b] = '0;
            if (stable_ms[b] >= debounce_ms) begin
              since_press[b] = '0;
              down_ms[b] = '0;
              stable_ms[b] = '0;
              lane_mode[b] = MODE_PRESSED;
            end
          end else begin
            if (!high) begin
              stable_ms[b] = '0;
              if (down_ms[b] >= hold_ms) lane_mode[b] = MODE_HELD;
            end
            if (stable_ms[b] >= debounce_ms) begin
              since_release[b] = '0;
              stable_ms[b] = '0;
              lane_mode[b] = MODE_RELEASED;
            end
          end
        end
      end
      CMD_RISE: begin
        s.seen = (since_press[w.idx] < window_ms) && (uptime >= window_ms);
        since_press[w.idx] = AGE_MAX;
      end
      CMD_FALL: begin
        s.seen = (since_release[w.idx] < window_ms) && (uptime >= window_ms);
        since_release[w.idx] = AGE_MAX;
      end
      default: ;
    endcase
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      s.pressed[b] = (lane_mode[b] != MODE_RELEASED);
      s.held[b] = (lane_mode[b] == MODE_HELD);
    end
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    button_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        w.cmd = in_cmd;
        w.pins = in_pin_levels;
        w.idx = in_button_index;
        expected_status.push_back(apply_word(w));
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_cmd <= w.cmd;
          in_pin_levels <= w.pins;
          in_button_index <= w.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    button_status_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          err_count++;
          $error("result word with nothing expected");
        end else begin
          want = expected_status.pop_front();
          check_field("pressed_mask", 32'(want.pressed), 32'(out_pressed_mask));
          check_field("held_mask", 32'(want.held), 32'(out_held_mask));
          check_field("edge_seen", 32'(want.seen), 32'(out_edge_seen));
        end
      end
      if (rx_pause_left > 0) begin
        rx_pause_left--;
        out_ready <= 1'b0;
      end else if (rx_pause_seen != rx_pause_req) begin
        rx_pause_seen = rx_pause_req;
        rx_pause_left = RX_PAUSE_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("button_debounce_hold_edge verification failed");
      $finish;
    end
  end

  task automatic queue_word(input logic [1:0] c, input logic [NUM_BUTTONS-1:0] p,
                            input logic i);
    button_word_t w;
    w.cmd = c;
    w.pins = p;
    w.idx = i;
    pending_words.push_back(w);
  endtask

  task automatic queue_ticks(input int n, input logic [NUM_BUTTONS-1:0] p);
    repeat (n) queue_word(CMD_TICK, p, 1'b0);
  endtask

  task automatic queue_random_words(input int n);
    int r;
    logic [NUM_BUTTONS-1:0] glitch;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 12) begin
        queue_word($urandom_range(1) ? CMD_RISE : CMD_FALL, NUM_BUTTONS'($urandom),
                   1'($urandom));
      end else if (r < 14) begin
        queue_word(CMD_SPARE, NUM_BUTTONS'($urandom), 1'($urandom));
      end else begin
        for (int b = 0; b < NUM_BUTTONS; b++)
          if ($urandom_range(99) < 8) pin_rest[b] = ~pin_rest[b];
        glitch = '0;
        if ($urandom_range(99) < 5) glitch[$urandom_range(NUM_BUTTONS - 1)] = 1'b1;
        queue_word(CMD_TICK, pin_rest ^ glitch, 1'($urandom));
      end
    end
  endtask

  // wait until the block has nothing in flight
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic start_phase(input int mode, input logic [AGE_W-1:0] d,
                             input logic [AGE_W-1:0] h, input logic [AGE_W-1:0] w);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEBOUNCE_TIME;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_index <= REG_HOLD_TIME;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= REG_EDGE_WINDOW;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_ms = d;
    hold_ms = h;
    window_ms = w;
    case (mode)
      1: begin send_idle_pct = 56; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 56; end
      3: begin send_idle_pct = 14; recv_stall_pct = 14; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  initial begin
    clear_debouncer();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration
    queue_word(CMD_RISE, 2'b11, 1'b0);
    queue_ticks(55, 2'b00);
    queue_word(CMD_RISE, 2'b00, 1'b0);
    queue_word(CMD_RISE, 2'b00, 1'b1);
    queue_word(CMD_FALL, 2'b00, 1'b0);
    queue_ticks(60, 2'b11);
    queue_word(CMD_FALL, 2'b11, 1'b0);
    queue_word(CMD_FALL, 2'b11, 1'b1);
    queue_word(CMD_RISE, 2'b11, 1'b0);

    // press, debounce restart, hold, release and edge expiry
    start_phase(0, 16'd2, 16'd3, 16'd4);
    queue_word(CMD_SPARE, 2'b11, 1'b1);
    queue_ticks(1, 2'b00);
    queue_ticks(1, 2'b11);
    queue_ticks(2, 2'b00);
    queue_word(CMD_RISE, 2'b00, 1'b0);
    queue_word(CMD_RISE, 2'b00, 1'b0);
    queue_ticks(3, 2'b00);
    queue_ticks(1, 2'b01);
    queue_ticks(1, 2'b00);
    queue_ticks(2, 2'b11);
    queue_word(CMD_FALL, 2'b11, 1'b1);
    queue_word(CMD_FALL, 2'b11, 1'b0);
    queue_ticks(5, 2'b11);
    queue_word(CMD_RISE, 2'b11, 1'b1);
    queue_word(CMD_FALL, 2'b11, 1'b1);
    queue_word(CMD_SPARE, 2'b10, 1'b0);

    // zero and unit settings
    start_phase(0, 16'd0, 16'd0, 16'd0);
    queue_random_words(40);
    start_phase(1, 16'd1, 16'd1, 16'd1);
    queue_random_words(60);
    queue_ticks(6, 2'b11);

    // full-scale settings
    start_phase(0, AGE_MAX, AGE_MAX, AGE_MAX);
    queue_ticks(40, 2'b10);
    queue_word(CMD_RISE, 2'b10, 1'b0);
    queue_word(CMD_RISE, 2'b10, 1'b1);
    queue_ticks(3, 2'b11);
    queue_word(CMD_FALL, 2'b11, 1'b0);

    for (int k = 0; k < 8; k++) begin
      start_phase(k % 4, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 24)),
                  16'($urandom_range(1, 30)));
      if (k == 4) rx_pause_req++;
      queue_random_words(190);
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("button_debounce_hold_edge verification clean");
    end else begin
      $display("button_debounce_hold_edge verification failed");
    end
    $finish;
  end

endmodule
